// ===== hw/rtl/assert_macros.svh =====
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPLIES(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("implication check failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("next-cycle check failed");

`endif

// ===== hw/rtl/jbpc_pkg.sv =====
// constants, codes and types for the jitter buffer playout controller
// no dependencies
package jbpc_pkg;

  localparam int unsigned SAMPLE_RATE    = 16000;
  localparam int unsigned FRAME_SAMPLES  = 320;
  // sample rate is taken to be a whole number of samples per millisecond
  localparam int unsigned SAMPLES_PER_MS = SAMPLE_RATE / 1000;

  localparam int unsigned MAX_MS       = 300;
  localparam int unsigned SILENCE_MS   = 400;
  localparam int unsigned TARGET_LOW   = 40;
  localparam int unsigned TARGET_HIGH  = 300;
  localparam int unsigned TARGET_RESET = 60;
  localparam int unsigned CONCEAL_CAP  = 8;

  localparam int unsigned TARGET_W  = 9;
  localparam int unsigned PREFILL_W = $clog2(TARGET_HIGH * SAMPLES_PER_MS + 1);
  localparam int unsigned MAX_W     = PREFILL_W + 1;
  localparam int unsigned MAX_FLOOR = MAX_MS * SAMPLES_PER_MS;
  localparam int unsigned TRIM_PROD_W = $clog2(4095 * SAMPLES_PER_MS + 1);
  localparam int unsigned WANT_W    = (TRIM_PROD_W > 16) ? TRIM_PROD_W : 16;

  localparam logic [2:0] ACT_PUSH  = 3'd0;
  localparam logic [2:0] ACT_TICK  = 3'd1;
  localparam logic [2:0] ACT_EOS   = 3'd2;
  localparam logic [2:0] ACT_FLUSH = 3'd3;
  localparam logic [2:0] ACT_TRIM  = 3'd4;

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_PREFILL = 2'd1;
  localparam logic [1:0] MODE_PLAYING = 2'd2;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] now_ms;
    logic [15:0] fill_level;
    logic [10:0] packet_samples;
    logic [3:0]  concealed_frames;
    logic [12:0] refused_samples;
    logic [11:0] trim_ms;
  } item_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] last_audio_time;
    logic        audio_seen;
    logic [31:0] dropped_count;
    logic [31:0] underrun_count;
    logic [31:0] frame_count;
    logic [31:0] conceal_count;
  } state_t;

  typedef struct packed {
    logic [15:0] drop_request;
    logic        flush_request;
  } request_t;

endpackage

// ===== hw/rtl/jbpc_step.sv =====
// next-state and request logic for one request of the playout controller
// depends on jbpc_pkg
module jbpc_step (
  input  jbpc_pkg::item_t                  item,
  input  jbpc_pkg::state_t                 state,
  input  logic [jbpc_pkg::PREFILL_W-1:0]   prefill,
  input  logic [jbpc_pkg::MAX_W-1:0]       maximum,
  output jbpc_pkg::state_t                 state_next,
  output jbpc_pkg::request_t               req
);
  import jbpc_pkg::*;

  logic              silent;
  logic [3:0]        conc_add;
  logic [WANT_W-1:0] want;
  logic [15:0]       want_capped;
  logic [31:0]       since_audio;

  assign since_audio = item.now_ms - state.last_audio_time;
  assign silent      = state.audio_seen && (since_audio > 32'(SILENCE_MS));
  assign conc_add    = (item.concealed_frames > 4'(CONCEAL_CAP)) ? 4'(CONCEAL_CAP)
                                                                 : item.concealed_frames;
  assign want        = WANT_W'(item.trim_ms) * WANT_W'(SAMPLES_PER_MS);
  assign want_capped = (want > WANT_W'(item.fill_level)) ? item.fill_level : want[15:0];

  always_comb begin
    state_next = state;
    req        = '0;
    case (item.action)
      ACT_PUSH: begin
        state_next.conceal_count = state.conceal_count + 32'(conc_add);
        state_next.dropped_count = state.dropped_count + 32'(item.refused_samples);
        if (item.packet_samples != '0) begin
          state_next.frame_count     = state.frame_count + 32'd1;
          state_next.last_audio_time = item.now_ms;
          state_next.audio_seen      = 1'b1;
          if (state.mode == MODE_IDLE) begin
            state_next.mode = MODE_PREFILL;
          end
        end
      end
      ACT_TICK: begin
        if (state.mode == MODE_PREFILL) begin
          if ((32'(item.fill_level) >= 32'(prefill)) || silent) begin
            state_next.mode = MODE_PLAYING;
          end
        end else if (state.mode == MODE_PLAYING) begin
          if (item.fill_level == '0) begin
            if (!state.audio_seen || silent) begin
              state_next.mode = MODE_IDLE;
            end else begin
              state_next.mode           = MODE_PREFILL;
              state_next.underrun_count = state.underrun_count + 32'd1;
            end
          end else if (32'(item.fill_level) > 32'(maximum)) begin
            req.drop_request         = 16'(FRAME_SAMPLES);
            state_next.dropped_count = state.dropped_count + 32'(FRAME_SAMPLES);
          end
        end
      end
      ACT_EOS: begin
        state_next.audio_seen      = 1'b0;
        state_next.last_audio_time = '0;
        if (state.mode == MODE_PREFILL) begin
          state_next.mode = MODE_PLAYING;
        end
      end
      ACT_FLUSH: begin
        req.flush_request          = 1'b1;
        state_next.mode            = MODE_IDLE;
        state_next.audio_seen      = 1'b0;
        state_next.last_audio_time = '0;
      end
      ACT_TRIM: begin
        // capped at what the ring holds
        req.drop_request         = want_capped;
        state_next.dropped_count = state.dropped_count + 32'(want_capped);
      end
      default: begin
        state_next = state;
      end
    endcase
  end

endmodule

// ===== hw/rtl/jitter_buffer_playout_control.sv =====
// playout controller for a voice jitter buffer: idle, prefill and playing
// a request accepted into the input register is stepped into the result register
// throughput: one request per cycle, stalls only when the result register is held
// reset (rst, synchronous) returns to idle, zeroes the counters, target 60 ms
// depends on jbpc_pkg, jbpc_step and assert_macros.svh
`include "assert_macros.svh"

module jitter_buffer_playout_control (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  action,
  input  logic [31:0] now_ms,
  input  logic [15:0] fill_level,
  input  logic [10:0] packet_samples,
  input  logic [3:0]  concealed_frames,
  input  logic [12:0] refused_samples,
  input  logic [11:0] trim_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        gate_open,
  output logic [1:0]  play_state,
  output logic [15:0] drop_request,
  output logic        flush_request,
  output logic [31:0] dropped_total,
  output logic [31:0] underrun_total,
  output logic [31:0] frame_total,
  output logic [31:0] concealed_total
);
  import jbpc_pkg::*;

  logic [TARGET_W-1:0]  target_clamped;
  logic [PREFILL_W-1:0] prefill;
  logic [PREFILL_W-1:0] prefill_next;
  logic [MAX_W-1:0]     maximum;
  logic [MAX_W-1:0]     maximum_next;
  logic [MAX_W-1:0]     twice;

  logic     item_valid;
  item_t    item;
  state_t   state;
  state_t   state_next;
  request_t req;
  logic     advance;

  // target is clamped on write; only the thresholds in samples derived from it are kept
  assign target_clamped = (cfg_data < 9'(TARGET_LOW))  ? 9'(TARGET_LOW)  :
                          (cfg_data > 9'(TARGET_HIGH)) ? 9'(TARGET_HIGH) : cfg_data;
  assign prefill_next   = PREFILL_W'(target_clamped * PREFILL_W'(SAMPLES_PER_MS));
  assign twice          = MAX_W'(prefill_next) << 1;
  assign maximum_next   = (twice > MAX_W'(MAX_FLOOR)) ? twice : MAX_W'(MAX_FLOOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      prefill <= PREFILL_W'(TARGET_RESET * SAMPLES_PER_MS);
      maximum <= (2 * TARGET_RESET > MAX_MS) ? MAX_W'(2 * TARGET_RESET * SAMPLES_PER_MS)
                                             : MAX_W'(MAX_FLOOR);
    end else if (cfg_write) begin
      prefill <= prefill_next;
      maximum <= maximum_next;
    end
  end

  // input register feeds the step logic; result register parts the two sides
  assign advance  = !out_valid || !out_stall;
  assign in_stall = item_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!in_stall) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= '{action:           action,
                now_ms:           now_ms,
                fill_level:       fill_level,
                packet_samples:   packet_samples,
                concealed_frames: concealed_frames,
                refused_samples:  refused_samples,
                trim_ms:          trim_ms};
    end
  end

  jbpc_step u_step (
    .item       (item),
    .state      (state),
    .prefill    (prefill),
    .maximum    (maximum),
    .state_next (state_next),
    .req        (req)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '{mode: MODE_IDLE, default: '0};
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= item_valid;
      if (item_valid) begin
        state <= state_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item_valid) begin
      drop_request  <= req.drop_request;
      flush_request <= req.flush_request;
    end
  end

  // the counters and mode in state are what was just stepped
  assign gate_open       = (state.mode == MODE_PLAYING);
  assign play_state      = state.mode;
  assign dropped_total   = state.dropped_count;
  assign underrun_total  = state.underrun_count;
  assign frame_total     = state.frame_count;
  assign concealed_total = state.conceal_count;

  `ASSERT_NEXT(a_item_reaches_output, clk, rst, item_valid && advance, out_valid)
  `ASSERT_IMPLIES(a_flush_goes_idle, clk, rst, out_valid && flush_request,
                  play_state == MODE_IDLE && drop_request == 16'd0)
  `ASSERT_IMPLIES(a_underrun_steps_by_one, clk, rst,
                  !$past(rst) && state.underrun_count != $past(state.underrun_count),
                  state.underrun_count == $past(state.underrun_count) + 32'd1
                  && state.mode == MODE_PREFILL)
  `ASSERT_IMPLIES(a_held_state_while_stalled, clk, rst,
                  !$past(rst) && $past(out_valid && out_stall), $stable(state))

endmodule
